// ===== rtl/hashed_coordinate_noise_pixel_macros.svh =====
// Assertion macros for the hashed coordinate noise pixel block.
// Expects clk and rst_n in the scope of use.
`ifndef HASHED_COORDINATE_NOISE_PIXEL_MACROS_SVH
`define HASHED_COORDINATE_NOISE_PIXEL_MACROS_SVH

// same-cycle implication
`define HCN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hcn_pkg.sv =====
// Shared types, constants and hash helpers for the coordinate noise pixel block.
// No dependencies.
package hcn_pkg;

  localparam int unsigned COORD_W           = 16;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned CFG_DATA_W        = 33;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned NUM_COMP          = 4;
  localparam int unsigned NUM_KEYS          = NUM_COMP + 1;
  localparam int unsigned COMP_W            = 16;

  localparam logic [WORD_W-1:0] WANG_XOR = 32'd61;
  localparam logic [WORD_W-1:0] WANG_MUL = 32'h27d4eb2d;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED      = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_GAIN      = 3'd2,
    REG_MEAN      = 3'd3,
    REG_COUNT     = 3'd4,
    REG_DEPTH     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [COMP_W-1:0] comp0;
    logic [COMP_W-1:0] comp1;
    logic [COMP_W-1:0] comp2;
    logic [COMP_W-1:0] comp3;
    logic              lit;
  } out_word_t;

  function automatic logic [WORD_W-1:0] sext_coord(logic [COORD_W-1:0] v);
    return {{(WORD_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // integer hash up to (not including) the multiply
  function automatic logic [WORD_W-1:0] wang_pre(logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] a1;
    logic [WORD_W-1:0] a2;
    a1 = (a ^ WANG_XOR) ^ (a >> 16);
    a2 = a1 + (a1 << 3);
    return a2 ^ (a2 >> 4);
  endfunction

endpackage

// ===== rtl/hcn_wang.sv =====
// Two-stage integer hash: shift/xor front end, then constant multiply.
// The final xorshift is combinational on the output, in the consumer's stage. Uses hcn_pkg.
module hcn_wang
  import hcn_pkg::*;
(
  input  logic              clk,
  input  logic [1:0]        en,
  input  logic [WORD_W-1:0] key_in,
  output logic [WORD_W-1:0] hash_out
);

  logic [WORD_W-1:0] pre_r;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] prod_nxt;

  assign prod_nxt = pre_r * WANG_MUL;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pre_r <= wang_pre(key_in);
    end
    if (en[1]) begin
      prod_r <= prod_nxt;
    end
  end

  assign hash_out = prod_r ^ (prod_r >> 15);

endmodule

// ===== rtl/hcn_scale.sv =====
// Three-stage component scaler: centre the hash word, multiply by gain,
// add to mean with saturation; final scale to 255/65535 on the output. Uses hcn_pkg.
module hcn_scale
  import hcn_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  logic [WORD_W-1:0]         word_in,
  input  logic [FRACTION_BITS+7:0]  noise_gain,
  input  logic [FRACTION_BITS+7:0]  mean_level,
  input  logic                      depth_mode,
  output logic [COMP_W-1:0]         level_out
);

  localparam int unsigned LEVEL_W = FRACTION_BITS + 8;
  localparam int unsigned PROD_W  = LEVEL_W + WORD_W;
  localparam int unsigned V_W     = FRACTION_BITS + WORD_W;

  // stage 1: sign and magnitude of word - 2^31
  logic              neg_r;
  logic [WORD_W-1:0] mag_r;
  // stage 2: gain * magnitude
  logic              neg2_r;
  logic [PROD_W-1:0] prod_r;
  // stage 3: level with saturation flags
  logic              sat_max_r;
  logic              sat_zero_r;
  logic [V_W-1:0]    v_r;

  logic [PROD_W-1:0] base;
  logic [PROD_W:0]   sum;
  logic [PROD_W-1:0] diff;
  logic              sat_max_nxt;
  logic              sat_zero_nxt;
  logic [V_W-1:0]    v_nxt;

  logic [V_W+15:0]   scaled16;
  logic [V_W+7:0]    scaled8;
  logic [COMP_W-1:0] maxv;

  assign base = {mean_level, {WORD_W{1'b0}}};
  assign sum  = {1'b0, base} + {1'b0, prod_r};
  assign diff = base - prod_r;

  always_comb begin
    sat_max_nxt  = 1'b0;
    sat_zero_nxt = 1'b0;
    v_nxt        = sum[V_W-1:0];
    if (!neg2_r) begin
      sat_max_nxt = |sum[PROD_W:V_W];
    end else if (prod_r >= base) begin
      sat_zero_nxt = 1'b1;
    end else begin
      v_nxt       = diff[V_W-1:0];
      sat_max_nxt = |diff[PROD_W-1:V_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_r <= ~word_in[WORD_W-1];
      mag_r <= word_in[WORD_W-1] ? {1'b0, word_in[WORD_W-2:0]}
                                 : (32'h8000_0000 - word_in);
    end
    if (en[1]) begin
      neg2_r <= neg_r;
      prod_r <= PROD_W'(noise_gain) * PROD_W'(mag_r);
    end
    if (en[2]) begin
      sat_max_r  <= sat_max_nxt;
      sat_zero_r <= sat_zero_nxt;
      v_r        <= v_nxt;
    end
  end

  // level * (2^n - 1) as shift and subtract, exact floor after dropping V_W bits
  assign scaled16 = {v_r, 16'd0} - (V_W+16)'(v_r);
  assign scaled8  = {v_r, 8'd0} - (V_W+8)'(v_r);
  assign maxv     = depth_mode ? 16'hFFFF : 16'h00FF;

  always_comb begin
    if (sat_max_r) begin
      level_out = maxv;
    end else if (sat_zero_r) begin
      level_out = '0;
    end else if (depth_mode) begin
      level_out = scaled16[V_W+15:V_W];
    end else begin
      level_out = {8'd0, scaled8[V_W+7:V_W]};
    end
  end

endmodule

// ===== rtl/hashed_coordinate_noise_pixel.sv =====
// Throughput: one pixel per clock; every stage holds under output back-pressure
// and bubbles close up, so input stalls only when all 10 stages are full.
// Stages: two hash multiplies in series, five hashes in parallel, then scaling.
// Reset: pipeline valids cleared, configuration back to defaults (all lit,
// gain and mean 0.5, four components, 8-bit depth, seed 0).
`include "hashed_coordinate_noise_pixel_macros.svh"

module hashed_coordinate_noise_pixel
  import hcn_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LEVEL_W = FRACTION_BITS + 8;
  localparam int unsigned N_STG   = 10;
  localparam logic [LEVEL_W-1:0] HALF = LEVEL_W'(1) << (FRACTION_BITS - 1);

  // configuration
  logic [WORD_W-1:0]     seed_r;
  logic [CFG_DATA_W-1:0] thresh_r;
  logic [LEVEL_W-1:0]    gain_r;
  logic [LEVEL_W-1:0]    mean_r;
  logic [2:0]            count_r;
  logic                  depth_r;
  logic [2:0]            count_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      thresh_r <= 33'h1_0000_0000;
      gain_r   <= HALF;
      mean_r   <= HALF;
      count_r  <= 3'd4;
      depth_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SEED:      seed_r   <= cfg_wdata[WORD_W-1:0];
        REG_THRESHOLD: thresh_r <= cfg_wdata;
        REG_GAIN:      gain_r   <= cfg_wdata[LEVEL_W-1:0];
        REG_MEAN:      mean_r   <= cfg_wdata[LEVEL_W-1:0];
        REG_COUNT:     count_r  <= cfg_wdata[2:0];
        REG_DEPTH:     depth_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_r == 3'd0) begin
      count_eff = 3'd1;
    end else if (count_r > 3'd4) begin
      count_eff = 3'd4;
    end else begin
      count_eff = count_r;
    end
  end

  // valid chain, each stage loads when empty or when the next one moves
  logic [N_STG-1:0] vld_r;
  logic [N_STG-1:0] en;

  always_comb begin
    en[N_STG-1] = ~vld_r[N_STG-1] | out_ready;
    for (int k = N_STG - 2; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // hash chain
  logic [WORD_W-1:0] y0_r;
  logic [WORD_W-1:0] y1_r;
  logic [WORD_W-1:0] hash_a;
  logic [WORD_W-1:0] inner;
  logic [WORD_W-1:0] key_h [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y0_r <= sext_coord(in_word.pixel_y);
    end
    if (en[1]) begin
      y1_r <= y0_r;
    end
  end

  hcn_wang u_hash_x (
    .clk      (clk),
    .en       (en[1:0]),
    .key_in   (seed_r ^ sext_coord(in_word.pixel_x)),
    .hash_out (hash_a)
  );

  hcn_wang u_hash_y (
    .clk      (clk),
    .en       (en[3:2]),
    .key_in   (hash_a ^ y1_r),
    .hash_out (inner)
  );

  // keys 0..3 are the components, the last one gates the pixel
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
    logic [WORD_W-1:0] key;
    if (g < NUM_COMP) begin : g_comp
      assign key = inner ^ WORD_W'(g);
    end else begin : g_gate
      assign key = inner ^ WORD_W'(count_eff);
    end
    hcn_wang u_hash_k (
      .clk      (clk),
      .en       (en[5:4]),
      .key_in   (key),
      .hash_out (key_h[g])
    );
  end

  // gate result travels alongside the scalers
  logic lit6_r;
  logic lit7_r;
  logic lit8_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      lit6_r <= ({1'b0, key_h[NUM_COMP]} <= thresh_r);
    end
    if (en[7]) begin
      lit7_r <= lit6_r;
    end
    if (en[8]) begin
      lit8_r <= lit7_r;
    end
  end

  logic [COMP_W-1:0] level [NUM_COMP];

  for (genvar g = 0; g < NUM_COMP; g++) begin : g_scale
    hcn_scale #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
      .clk        (clk),
      .en         (en[8:6]),
      .word_in    (key_h[g]),
      .noise_gain (gain_r),
      .mean_level (mean_r),
      .depth_mode (depth_r),
      .level_out  (level[g])
    );
  end

  // output register, unlit pixels and unused components forced to zero
  out_word_t out_r;
  out_word_t out_nxt;
  logic [COMP_W-1:0] gated [NUM_COMP];

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      gated[c] = (lit8_r && (3'(c) < count_eff)) ? level[c] : '0;
    end
    out_nxt.comp0 = gated[0];
    out_nxt.comp1 = gated[1];
    out_nxt.comp2 = gated[2];
    out_nxt.comp3 = gated[3];
    out_nxt.lit   = lit8_r;
  end

  always_ff @(posedge clk) begin
    if (en[N_STG-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[N_STG-1];
  assign out_word  = out_r;

  `HCN_ASSERT_IMP(a_full_when_blocked, !in_ready, &vld_r,
    "input blocked while the pipeline has a bubble")
  `HCN_ASSERT_NXT(a_bubble_reaches_out, out_valid && out_ready && !vld_r[N_STG-2], !out_valid,
    "output valid invented from an empty stage")
  `HCN_ASSERT_IMP(a_unlit_zero, out_valid && !out_word.lit,
    (out_word.comp0 == '0) && (out_word.comp1 == '0) && (out_word.comp2 == '0)
    && (out_word.comp3 == '0), "unlit pixel with non-zero component")
  `HCN_ASSERT_IMP(a_narrow_depth, out_valid && !depth_r,
    (out_word.comp0[15:8] == 8'd0) && (out_word.comp1[15:8] == 8'd0)
    && (out_word.comp2[15:8] == 8'd0) && (out_word.comp3[15:8] == 8'd0),
    "8-bit depth component above 255")
  `HCN_ASSERT_IMP(a_unused_zero, out_valid && (count_eff < 3'd4), out_word.comp3 == '0,
    "unused component not zero")

endmodule
